// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both macros compile away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/pcs_pkg.sv =====
package pcs_pkg;

    // Sieve capacity and the widths that follow from it.
    localparam int MAX_LIMIT = 65536;
    localparam int ADDR_W    = $clog2(MAX_LIMIT);
    localparam int LIMIT_W   = 17;
    localparam int COUNT_W   = 13;
    localparam int PRIME_W   = 9;
    localparam int SQ_W      = 18;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_CHECK,
        ST_MARK,
        ST_COUNT,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/prime_count_sieve_top.sv =====
// Prime counter built on a Sieve of Eratosthenes over a one-bit scratch memory.
// Input channel (s_axis): one transfer carries a limit; the block counts the
// primes strictly below it. Output channel (m_axis): one transfer per input,
// carrying the count and a flag set when the limit exceeds the sieve capacity
// (the count is then zero). Limits of 0 and 1 return zero without touching memory.
// One limit is processed at a time. For a limit n of 2 up to the capacity an item
// runs an initialization pass over the entries below n, then a scan of candidates
// p with p*p below n, in which each prime found has its multiples from p*p upward
// cleared, then a counting pass. The bitmap memory has a single write port and a
// single read port, so the initialization, marking and counting passes each move
// one entry per cycle. Small or oversized limits go straight from idle to the
// done state. The next limit is accepted as soon as the result has been loaded
// into the output register, even while that result waits for the receiver. When
// the receiver stalls with a result still held, a newly finished result waits in
// the sequencer until the register frees.
// Reset (synchronous, active low) returns the sequencer to idle and empties the
// output register. The bitmap needs no clearing after reset, because every item
// rewrites each entry below its limit before reading it.
module prime_count_sieve_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // Fields from bit 0: limit[16:0], zero padding.
    input  logic [pcs_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // Fields from bit 0: prime_count[12:0], zero padding.
    output logic [pcs_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // Fields from bit 0: too_large.
    output logic                         o_m_axis_tuser
);

    localparam int LW = pcs_pkg::LIMIT_W;
    localparam int AW = pcs_pkg::ADDR_W;
    localparam int CW = pcs_pkg::COUNT_W;
    localparam int PW = pcs_pkg::PRIME_W;
    localparam int QW = pcs_pkg::SQ_W;

    pcs_pkg::t_state r_state, n_state;

    logic [LW-1:0] r_n, n_n;        // limit of the item at work
    logic [LW-1:0] r_j, n_j;        // sweep index for init, marking and counting
    logic [PW-1:0] r_p, n_p;        // candidate prime
    logic [QW-1:0] r_sq, n_sq;      // r_p squared, kept incrementally
    logic [CW-1:0] r_total, n_total;
    logic          r_big, n_big;
    logic          r_rd_vld, n_rd_vld;

    logic          r_out_vld, n_out_vld;
    logic [CW-1:0] r_out_cnt, n_out_cnt;
    logic          r_out_big, n_out_big;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata;

    logic          in_xfer;
    logic          out_xfer;
    logic [LW-1:0] in_limit;
    logic [LW-1:0] last_j;
    logic [QW-1:0] sq_step;

    assign in_limit = i_s_axis_tdata[LW-1:0];
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_out_vld && i_m_axis_tready;
    assign last_j   = r_n - LW'(1);
    // (p+1)^2 = p^2 + 2p + 1
    assign sq_step  = QW'({r_p, 1'b0}) + QW'(1);

    pcs_bit_ram #(
        .ADDR_W (AW)
    ) u_bits (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pcs_pkg::ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_j       <= n_j;
        r_p       <= n_p;
        r_sq      <= n_sq;
        r_total   <= n_total;
        r_big     <= n_big;
        r_out_cnt <= n_out_cnt;
        r_out_big <= n_out_big;
    end

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_j       = r_j;
        n_p       = r_p;
        n_sq      = r_sq;
        n_total   = r_total;
        n_big     = r_big;
        n_rd_vld  = 1'b0;
        n_out_vld = r_out_vld && !out_xfer;
        n_out_cnt = r_out_cnt;
        n_out_big = r_out_big;
        mem_we    = 1'b0;
        mem_waddr = r_j[AW-1:0];
        mem_wdata = 1'b0;
        mem_raddr = r_j[AW-1:0];
        o_s_axis_tready = 1'b0;

        // Counting uses each read's data in the cycle after the read is issued.
        if (r_rd_vld && mem_rdata && (r_total != pcs_pkg::COUNT_MAX)) begin
            n_total = r_total + CW'(1);
        end

        unique case (r_state)
            pcs_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_n     = in_limit;
                    n_j     = '0;
                    n_total = '0;
                    n_big   = in_limit > LW'(pcs_pkg::MAX_LIMIT);
                    if (in_limit > LW'(pcs_pkg::MAX_LIMIT) || in_limit < LW'(2)) begin
                        n_state = pcs_pkg::ST_DONE;
                    end else begin
                        n_state = pcs_pkg::ST_INIT;
                    end
                end
            end
            pcs_pkg::ST_INIT: begin
                // Entries 0 and 1 are written as composite, the rest as prime.
                mem_we    = 1'b1;
                mem_wdata = r_j >= LW'(2);
                n_j       = r_j + LW'(1);
                if (r_j == last_j) begin
                    n_p     = PW'(2);
                    n_sq    = QW'(4);
                    n_state = pcs_pkg::ST_SCAN;
                end
            end
            pcs_pkg::ST_SCAN: begin
                mem_raddr = AW'(r_p);
                if (r_sq < QW'(r_n)) begin
                    n_state = pcs_pkg::ST_CHECK;
                end else if (r_n > LW'(2)) begin
                    n_j     = LW'(2);
                    n_state = pcs_pkg::ST_COUNT;
                end else begin
                    n_state = pcs_pkg::ST_DONE;
                end
            end
            pcs_pkg::ST_CHECK: begin
                if (mem_rdata) begin
                    n_j     = LW'(r_sq);
                    n_state = pcs_pkg::ST_MARK;
                end else begin
                    n_p     = r_p + PW'(1);
                    n_sq    = r_sq + sq_step;
                    n_state = pcs_pkg::ST_SCAN;
                end
            end
            pcs_pkg::ST_MARK: begin
                if (r_j < r_n) begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b0;
                    n_j       = r_j + LW'(r_p);
                end else begin
                    n_p     = r_p + PW'(1);
                    n_sq    = r_sq + sq_step;
                    n_state = pcs_pkg::ST_SCAN;
                end
            end
            pcs_pkg::ST_COUNT: begin
                n_rd_vld = 1'b1;
                n_j      = r_j + LW'(1);
                if (r_j == last_j) begin
                    n_state = pcs_pkg::ST_DRAIN;
                end
            end
            pcs_pkg::ST_DRAIN: begin
                n_state = pcs_pkg::ST_DONE;
            end
            pcs_pkg::ST_DONE: begin
                if (!r_out_vld || out_xfer) begin
                    n_out_vld = 1'b1;
                    n_out_cnt = r_total;
                    n_out_big = r_big;
                    n_state   = pcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(pcs_pkg::M_DATA_W - CW){1'b0}}, r_out_cnt};
    assign o_m_axis_tuser  = r_out_big;

`include "assert_macros.svh"

    `ASSERT_PROP(a_accept_starts_work, i_clk, i_rst_n,
        in_xfer |=> (r_state != pcs_pkg::ST_IDLE),
        "accepted limit did not start the sequencer")
    `ASSERT_PROP(a_check_after_scan, i_clk, i_rst_n,
        (r_state == pcs_pkg::ST_CHECK) |-> ($past(r_state) == pcs_pkg::ST_SCAN),
        "prime check without a read issued the cycle before")
    `ASSERT_PROP(a_write_below_limit, i_clk, i_rst_n,
        mem_we |-> (r_j < r_n),
        "bitmap write at or beyond the limit")
    `ASSERT_PROP(a_flag_means_zero, i_clk, i_rst_n,
        (r_out_vld && r_out_big) |-> (r_out_cnt == '0),
        "oversized limit returned a nonzero count")

endmodule

// ===== rtl/pcs_bit_ram.sv =====
module pcs_bit_ram #(
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata
);

    logic mem [0:(2**ADDR_W)-1];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
